>>> rtl/clns_pkg.sv
// Types and constants for the character LCD nibble sequencer.
// Used by every module in the rtl folder; depends on nothing.
package clns_pkg;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_COMMAND = 2'd1;
    localparam logic [1:0] ACT_CHAR    = 2'd2;
    localparam logic [1:0] ACT_CURSOR  = 2'd3;

    localparam logic [1:0] LINE_ONE = 2'd1;
    localparam logic [1:0] LINE_TWO = 2'd2;

    localparam logic CFG_FUNCTION_SET    = 1'b0;
    localparam logic CFG_DISPLAY_CONTROL = 1'b1;

    localparam logic [7:0] FUNCTION_SET_RESET    = 8'h28;
    localparam logic [7:0] DISPLAY_CONTROL_RESET = 8'h0C;

    localparam logic [3:0] WAKE_NIBBLE = 4'h3;

    localparam logic [7:0] STEP_WAKE_FIRST  = 8'd20;
    localparam logic [7:0] STEP_WAKE_SECOND = 8'd15;
    localparam logic [7:0] STEP_WAKE_THIRD  = 8'd12;
    localparam logic [7:0] STEP_FUNC_NIBBLE = 8'd6;
    localparam logic [7:0] STEP_FUNC_BYTE   = 8'd4;
    localparam logic [7:0] STEP_DISPLAY     = 8'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_value;
        logic [1:0] line_number;
        logic [5:0] column;
    } item_t;

    typedef struct packed {
        logic       register_select;
        logic [3:0] data_nibble;
        logic       enable_pulse;
        logic       last;
    } result_t;

    // One stored word carries an optional mode switch followed by an optional byte.
    typedef struct packed {
        logic       sw;
        logic       to_char;
        logic       has_byte;
        logic [7:0] data;
    } q_word_t;

    typedef struct packed {
        logic    push;
        logic    push_two;
        q_word_t word;
        logic    pop;
        logic    advance;
    } q_ctrl_t;

    typedef struct packed {
        logic    load;
        logic    two;
        result_t r0;
        result_t r1;
    } ob_load_t;

endpackage

>>> rtl/clns_queue.sv
// Pending entry queue: one memory word per push, registered head word with write bypass.
// Depends on clns_pkg.
module clns_queue #(
    parameter int DEPTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  clns_pkg::q_ctrl_t          ctrl,
    output clns_pkg::q_word_t          head,
    output logic [$clog2(DEPTH+1)-1:0] fill
);
    import clns_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    q_word_t           mem [DEPTH];
    q_word_t           head_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] push_amount;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        if (ctrl.advance)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        wr_ptr_next = wr_ptr_reg;
        if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        push_amount = '0;
        if (ctrl.push)
        begin
            push_amount = ctrl.push_two ? FILL_W'(2) : FILL_W'(1);
        end
        fill_next = fill_reg + push_amount - FILL_W'(ctrl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_ptr_reg] <= ctrl.word;
        end
        if (ctrl.push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= ctrl.word;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    assign head = head_reg;
    assign fill = fill_reg;

endmodule

>>> rtl/clns_out_buf.sv
// Two-slot result buffer that drives the result channel one transaction at a time.
// Depends on clns_pkg.
module clns_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  clns_pkg::ob_load_t ld,
    output logic               can_load,
    output logic               result_valid,
    input  logic               result_ready,
    output clns_pkg::result_t  result
);
    import clns_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    slot0_reg;
    result_t    slot1_reg;
    logic       pop;

    assign pop          = result_valid && result_ready;
    assign result_valid = (cnt_reg != 2'd0);
    assign result       = slot0_reg;
    assign can_load     = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ld.load)
        begin
            cnt_next = ld.two ? 2'd2 : 2'd1;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            slot0_reg <= ld.r0;
            slot1_reg <= ld.r1;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

>>> rtl/char_lcd_nibble_sequencer.sv
// Path: an accepted item waits in the input item register; its results then go through the
// two-slot result buffer, which a tick with two results fills. Throughput: one item per cycle
// while that buffer can take the results. Queue head is read from a registered memory port.
// Reset: asynchronous, active low; clears control state and configuration to defaults.
// The queue memory is not cleared; entries are read only after being written.
// Depends on clns_pkg, clns_queue and clns_out_buf.
module char_lcd_nibble_sequencer #(
    parameter int QUEUE_DEPTH   = 32,
    parameter int STARTUP_TICKS = 250
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              item_valid,
    output logic              item_ready,
    input  clns_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output clns_pkg::result_t result
);
    import clns_pkg::*;

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(QUEUE_DEPTH);
    localparam logic [FILL_W-1:0] FILL_ALMOST = FILL_W'(QUEUE_DEPTH - 1);
    localparam logic [7:0]        STARTUP_INIT = 8'(STARTUP_TICKS);

    logic        item_valid_reg;
    item_t       item_reg;
    logic [7:0]  func_set_reg;
    logic [7:0]  disp_ctrl_reg;
    logic [7:0]  startup_reg;
    logic [7:0]  startup_next;
    logic        mode_cmd_reg;
    logic        mode_cmd_next;
    logic        rs_reg;
    logic        rs_next;
    logic [3:0]  pin_reg;
    logic [3:0]  pin_next;
    logic        sw_done_reg;
    logic        sw_done_next;

    q_ctrl_t            q_req;
    q_ctrl_t            q_ctrl;
    q_word_t            head;
    logic [FILL_W-1:0]  fill;
    ob_load_t           ob_ld;
    logic               ob_can_load;
    result_t            res0;
    result_t            res1;
    logic               n_one;
    logic               n_two;
    logic               has_res;
    logic               advance;
    logic [7:0]         push_byte;
    logic               push_cmd;
    logic               need_sw;

    clns_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (q_ctrl),
        .head (head),
        .fill (fill)
    );

    clns_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .ld          (ob_ld),
        .can_load    (ob_can_load),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always_comb
    begin
        res0          = '0;
        res1          = '0;
        n_one         = 1'b0;
        n_two         = 1'b0;
        startup_next  = startup_reg;
        mode_cmd_next = mode_cmd_reg;
        rs_next       = rs_reg;
        pin_next      = pin_reg;
        sw_done_next  = sw_done_reg;
        q_req         = '0;
        push_byte     = item_reg.byte_value;
        if (item_reg.action == ACT_CURSOR)
        begin
            push_byte = {1'b1, item_reg.line_number == LINE_TWO, item_reg.column};
        end
        push_cmd = (item_reg.action != ACT_CHAR);
        need_sw  = (push_cmd != mode_cmd_reg);

        if (item_reg.action == ACT_TICK)
        begin
            if (startup_reg != 8'd0)
            begin
                startup_next = startup_reg - 8'd1;
                case (startup_reg)
                    STEP_WAKE_FIRST:
                    begin
                        pin_next = WAKE_NIBBLE;
                        res0     = '{rs_reg, WAKE_NIBBLE, 1'b1, 1'b1};
                        n_one    = 1'b1;
                    end
                    STEP_WAKE_SECOND, STEP_WAKE_THIRD:
                    begin
                        res0  = '{rs_reg, pin_reg, 1'b1, 1'b1};
                        n_one = 1'b1;
                    end
                    STEP_FUNC_NIBBLE:
                    begin
                        pin_next = func_set_reg[7:4];
                        res0     = '{rs_reg, func_set_reg[7:4], 1'b1, 1'b1};
                        n_one    = 1'b1;
                    end
                    STEP_FUNC_BYTE:
                    begin
                        pin_next = func_set_reg[3:0];
                        res0     = '{rs_reg, func_set_reg[7:4], 1'b1, 1'b0};
                        res1     = '{rs_reg, func_set_reg[3:0], 1'b1, 1'b1};
                        n_two    = 1'b1;
                    end
                    STEP_DISPLAY:
                    begin
                        pin_next = disp_ctrl_reg[3:0];
                        res0     = '{rs_reg, disp_ctrl_reg[7:4], 1'b1, 1'b0};
                        res1     = '{rs_reg, disp_ctrl_reg[3:0], 1'b1, 1'b1};
                        n_two    = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (fill != '0)
            begin
                q_req.pop = 1'b1;
                if (head.sw && !sw_done_reg)
                begin
                    rs_next = head.to_char;
                    res0    = '{head.to_char, pin_reg, 1'b0, 1'b1};
                    n_one   = 1'b1;
                    if (head.has_byte)
                    begin
                        sw_done_next = 1'b1;
                    end
                    else
                    begin
                        q_req.advance = 1'b1;
                    end
                end
                else
                begin
                    q_req.advance = 1'b1;
                    sw_done_next  = 1'b0;
                    pin_next      = head.data[3:0];
                    res0          = '{rs_reg, head.data[7:4], 1'b1, 1'b0};
                    res1          = '{rs_reg, head.data[3:0], 1'b1, 1'b1};
                    n_two         = 1'b1;
                end
            end
        end
        else if ((item_reg.action != ACT_CURSOR) || (item_reg.line_number == LINE_ONE)
                 || (item_reg.line_number == LINE_TWO))
        begin
            mode_cmd_next = push_cmd;
            if (fill != FILL_FULL)
            begin
                q_req.push         = 1'b1;
                q_req.word.sw      = need_sw;
                q_req.word.to_char = !push_cmd;
                if (need_sw && (fill == FILL_ALMOST))
                begin
                    q_req.word.has_byte = 1'b0;
                    q_req.word.data     = '0;
                    q_req.push_two      = 1'b0;
                end
                else
                begin
                    q_req.word.has_byte = 1'b1;
                    q_req.word.data     = push_byte;
                    q_req.push_two      = need_sw;
                end
            end
        end

        has_res = n_one || n_two;
        advance = item_valid_reg && (!has_res || ob_can_load);

        q_ctrl         = q_req;
        q_ctrl.push    = q_req.push && advance;
        q_ctrl.pop     = q_req.pop && advance;
        q_ctrl.advance = q_req.advance && advance;

        ob_ld.load = advance && has_res;
        ob_ld.two  = n_two;
        ob_ld.r0   = res0;
        ob_ld.r1   = res1;
    end

    assign item_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            func_set_reg   <= FUNCTION_SET_RESET;
            disp_ctrl_reg  <= DISPLAY_CONTROL_RESET;
            startup_reg    <= STARTUP_INIT;
            mode_cmd_reg   <= 1'b1;
            rs_reg         <= 1'b0;
            pin_reg        <= 4'd0;
            sw_done_reg    <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (cfg_we && (cfg_index == CFG_FUNCTION_SET))
            begin
                func_set_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_DISPLAY_CONTROL))
            begin
                disp_ctrl_reg <= cfg_data;
            end
            if (advance)
            begin
                startup_reg  <= startup_next;
                mode_cmd_reg <= mode_cmd_next;
                rs_reg       <= rs_next;
                pin_reg      <= pin_next;
                sw_done_reg  <= sw_done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

endmodule

>>> dv/lcd_sb_pkg.sv
// Scoreboard for the character LCD nibble sequencer: predicts the pin transactions
// caused by each accepted input transaction and checks the ones the block sends.
// Depends on clns_pkg for the transaction types and the startup constants.
package lcd_sb_pkg;

    import clns_pkg::*;

    localparam int FIFO_SLOTS = 32;
    localparam int BOOT_TICKS = 250;

    typedef enum logic [1:0] {
        ENTRY_BYTE    = 2'd0,
        ENTRY_TO_CHAR = 2'd1,
        ENTRY_TO_CMD  = 2'd2
    } entry_kind_e;

    typedef struct packed {
        entry_kind_e kind;
        logic [7:0]  data;
    } lcd_entry_t;

    class nibble_scoreboard;
        logic [7:0] func_set;
        logic [7:0] disp_ctrl;
        logic [7:0] boot_count;
        bit         cmd_mode;
        logic       rs_pin;
        logic [3:0] data_pins;
        lcd_entry_t pending_bytes[$];
        result_t    pin_events[$];
        int         mismatches;
        int         items_taken;
        int         ticks_taken;
        int         results_checked;
        int         drops;
        int         mode_switches;
        int         empty_ticks;

        function new();
            func_set        = FUNCTION_SET_RESET;
            disp_ctrl       = DISPLAY_CONTROL_RESET;
            boot_count      = 8'(BOOT_TICKS);
            cmd_mode        = 1'b1;
            rs_pin          = 1'b0;
            data_pins       = 4'h0;
            mismatches      = 0;
            items_taken     = 0;
            ticks_taken     = 0;
            results_checked = 0;
            drops           = 0;
            mode_switches   = 0;
            empty_ticks     = 0;
        endfunction

        function void write_reg(logic idx, logic [7:0] value);
            if (idx == CFG_FUNCTION_SET)
                func_set = value;
            else
                disp_ctrl = value;
        endfunction

        function void push_entry(entry_kind_e kind, logic [7:0] data);
            lcd_entry_t e;
            if (pending_bytes.size() >= FIFO_SLOTS)
            begin
                drops++;
                return;
            end
            e.kind = kind;
            e.data = data;
            pending_bytes.push_back(e);
        endfunction

        function void queue_byte(bit as_command, logic [7:0] data);
            if (as_command && !cmd_mode)
            begin
                push_entry(ENTRY_TO_CMD, 8'h00);
                cmd_mode = 1'b1;
            end
            else if (!as_command && cmd_mode)
            begin
                push_entry(ENTRY_TO_CHAR, 8'h00);
                cmd_mode = 1'b0;
            end
            push_entry(ENTRY_BYTE, data);
        endfunction

        function void emit(logic pulse);
            result_t r;
            r.register_select = rs_pin;
            r.data_nibble     = data_pins;
            r.enable_pulse    = pulse;
            r.last            = 1'b0;
            pin_events.push_back(r);
        endfunction

        function void send_nibble(logic [3:0] nib);
            data_pins = nib;
            emit(1'b1);
        endfunction

        function void send_byte(logic [7:0] data);
            send_nibble(data[7:4]);
            send_nibble(data[3:0]);
        endfunction

        function void run_tick();
            lcd_entry_t e;
            ticks_taken++;
            if (boot_count != 0)
            begin
                case (boot_count)
                    STEP_WAKE_FIRST:                  send_nibble(WAKE_NIBBLE);
                    STEP_WAKE_SECOND, STEP_WAKE_THIRD: emit(1'b1);
                    STEP_FUNC_NIBBLE:                 send_nibble(func_set[7:4]);
                    STEP_FUNC_BYTE:                   send_byte(func_set);
                    STEP_DISPLAY:                     send_byte(disp_ctrl);
                    default: ;
                endcase
                boot_count--;
            end
            else if (pending_bytes.size() != 0)
            begin
                e = pending_bytes.pop_front();
                case (e.kind)
                    ENTRY_TO_CHAR:
                    begin
                        rs_pin = 1'b1;
                        emit(1'b0);
                        mode_switches++;
                    end
                    ENTRY_TO_CMD:
                    begin
                        rs_pin = 1'b0;
                        emit(1'b0);
                        mode_switches++;
                    end
                    default: send_byte(e.data);
                endcase
            end
            else
                empty_ticks++;
        endfunction

        function void take_item(item_t it);
            int      before_count;
            result_t tail;
            before_count = pin_events.size();
            items_taken++;
            case (it.action)
                ACT_COMMAND: queue_byte(1'b1, it.byte_value);
                ACT_CHAR:    queue_byte(1'b0, it.byte_value);
                ACT_CURSOR:
                begin
                    if (it.line_number == LINE_ONE)
                        queue_byte(1'b1, {2'b10, it.column});
                    else if (it.line_number == LINE_TWO)
                        queue_byte(1'b1, {2'b11, it.column});
                end
                default: run_tick();
            endcase
            if (pin_events.size() > before_count)
            begin
                tail = pin_events.pop_back();
                tail.last = 1'b1;
                pin_events.push_back(tail);
            end
        endfunction

        function void check_pins(result_t got);
            result_t want;
            results_checked++;
            if (pin_events.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result transaction %0d arrived with none expected: rs=%0d d=%h e=%0d last=%0d",
                             results_checked, got.register_select, got.data_nibble,
                             got.enable_pulse, got.last);
                mismatches++;
                return;
            end
            want = pin_events.pop_front();
            if (got.register_select !== want.register_select ||
                got.data_nibble !== want.data_nibble ||
                got.enable_pulse !== want.enable_pulse ||
                got.last !== want.last)
            begin
                if (mismatches < 10)
                    $display("result transaction %0d: expected rs=%0d d=%h e=%0d last=%0d, got rs=%0d d=%h e=%0d last=%0d",
                             results_checked, want.register_select, want.data_nibble,
                             want.enable_pulse, want.last, got.register_select,
                             got.data_nibble, got.enable_pulse, got.last);
                mismatches++;
            end
        endfunction
    endclass

endpackage

>>> dv/tb.sv
// Top-level testbench for char_lcd_nibble_sequencer: runs the startup countdown with
// mixed traffic, then random phases under several register settings.
// Depends on clns_pkg, lcd_sb_pkg and the RTL of the block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clns_pkg::*;
    import lcd_sb_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int PHASES          = 5;
    localparam int TICK_SHARE [PHASES] = '{50, 20, 85, 50, 35};

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_we       = 1'b0;
    logic       cfg_index    = 1'b0;
    logic [7:0] cfg_data     = 8'h00;
    logic       item_valid   = 1'b0;
    logic       item_ready;
    item_t      item         = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    result_t    result;
    bit         steady       = 1'b0;
    int         cycles       = 0;

    nibble_scoreboard sb;

    char_lcd_nibble_sequencer #(
        .QUEUE_DEPTH   (FIFO_SLOTS),
        .STARTUP_TICKS (BOOT_TICKS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_pins(result);
    end

    always @(negedge clk)
    begin
        result_ready <= steady || ($urandom_range(99) >= 36);
    end

    function automatic item_t make_item(logic [1:0] act, logic [7:0] data,
                                        logic [1:0] line_sel, logic [5:0] col);
        item_t it;
        it.action      = act;
        it.byte_value  = data;
        it.line_number = line_sel;
        it.column      = col;
        return it;
    endfunction

    function automatic item_t random_item(int tick_pct);
        item_t it;
        it = make_item(ACT_TICK, 8'($urandom_range(255)), 2'($urandom_range(3)),
                       6'($urandom_range(63)));
        if ($urandom_range(99) >= tick_pct)
            it.action = 2'($urandom_range(3, 1));
        return it;
    endfunction

    task automatic send_item(input item_t it);
        while (!steady && $urandom_range(99) < 36)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.take_item(it);
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        item_valid <= 1'b0;
        while (sb.pin_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_reg(input logic idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        item_t it;
        sb = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_reg(CFG_FUNCTION_SET, 8'hFF);
        set_reg(CFG_DISPLAY_CONTROL, 8'h00);

        send_item(make_item(ACT_COMMAND, 8'h00, 2'd0, 6'd0));
        send_item(make_item(ACT_COMMAND, 8'hFF, 2'd3, 6'd63));
        send_item(make_item(ACT_CHAR, 8'h00, 2'd0, 6'd0));
        send_item(make_item(ACT_CHAR, 8'hFF, 2'd3, 6'd63));
        send_item(make_item(ACT_CURSOR, 8'h00, LINE_ONE, 6'd0));
        send_item(make_item(ACT_CHAR, 8'h41, 2'd0, 6'd0));
        send_item(make_item(ACT_CURSOR, 8'hFF, LINE_TWO, 6'd63));
        send_item(make_item(ACT_CURSOR, 8'h00, 2'd0, 6'd63));
        send_item(make_item(ACT_CURSOR, 8'hFF, 2'd3, 6'd0));
        send_item(make_item(ACT_TICK, 8'hFF, 2'd3, 6'd63));
        send_item(make_item(ACT_TICK, 8'h00, 2'd0, 6'd0));

        // The startup countdown, with the function-set and display-control registers
        // changed between the init steps that use them.
        while (sb.boot_count != 0)
        begin
            it = random_item(($urandom_range(99) < 40) ? 0 : 100);
            send_item(it);
            if (it.action == ACT_TICK && sb.boot_count == STEP_FUNC_NIBBLE - 1)
            begin
                wait_quiet();
                set_reg(CFG_FUNCTION_SET, 8'h5A);
            end
            else if (it.action == ACT_TICK && sb.boot_count == STEP_FUNC_BYTE - 1)
            begin
                wait_quiet();
                set_reg(CFG_DISPLAY_CONTROL, 8'hA5);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_quiet();
            case (phase)
                1:
                begin
                    set_reg(CFG_FUNCTION_SET, 8'h00);
                    set_reg(CFG_DISPLAY_CONTROL, 8'hFF);
                end
                3:
                begin
                    set_reg(CFG_FUNCTION_SET, 8'hFF);
                    set_reg(CFG_DISPLAY_CONTROL, 8'h00);
                end
                default:
                begin
                    set_reg(CFG_FUNCTION_SET, 8'($urandom_range(255)));
                    set_reg(CFG_DISPLAY_CONTROL, 8'($urandom_range(255)));
                end
            endcase
            steady = (phase == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(random_item(TICK_SHARE[phase]));
            steady = 1'b0;
        end

        wait_quiet();
        $display("Sent %0d input transactions (%0d ticks, %0d on an empty queue); checked %0d result transactions.",
                 sb.items_taken, sb.ticks_taken, sb.empty_ticks, sb.results_checked);
        $display("Saw %0d RS mode changes and %0d entries dropped on a full queue; %0d mismatches.",
                 sb.mode_switches, sb.drops, sb.mismatches);
        if (sb.mismatches == 0 && sb.pin_events.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
